// ===== design/bwrr_pkg.sv =====
// Shared types, constants and helper functions of the biased weighted round-robin unit.
package bwrr_pkg;

  // Geometry
  localparam int MAX_TARGETS = 8;
  localparam int SLOTS       = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int UPC_W       = 5;
  localparam int TOTAL_W     = 19;
  localparam int W_W         = 28;

  // Configuration register indexes
  localparam logic [2:0] CFG_SEED     = 3'd0;
  localparam logic [2:0] CFG_COUNT    = 3'd1;
  localparam logic [2:0] CFG_IMP_LOW  = 3'd2;
  localparam logic [2:0] CFG_IMP_HIGH = 3'd3;

  // Arithmetic constants
  localparam logic [31:0] HASH_MUL1   = 32'h7FEB_352D;
  localparam logic [31:0] HASH_MUL2   = 32'h846C_A68B;
  localparam logic [31:0] GOLDEN      = 32'h9E37_79B1;
  localparam logic [31:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam logic [15:0] IMP_FLOOR   = 16'd205;
  localparam logic [10:0] EMPH_ONE    = 11'd1024;
  localparam logic signed [47:0] CREDIT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] CREDIT_MIN = 48'sh8000_0000_0000;

  // Request and result payloads
  typedef struct packed {
    logic        req_type;
    logic [10:0] hero_emphasis;
  } req_t;

  typedef struct packed {
    logic [2:0] chosen_target;
    logic       is_favored;
  } res_t;

  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_PICK    = 1'b1;

  // Microcode fields
  typedef enum logic [2:0] {
    ACC_HOLD, ACC_SEED, ACC_HG, ACC_XS16, ACC_P_XS15, ACC_P_XS16, ACC_P_ADD5
  } acc_op_t;

  typedef enum logic [2:0] {
    MUL_NONE, MUL_C1, MUL_C2, MUL_TU, MUL_BN, MUL_DIV
  } mul_op_t;

  typedef enum logic [1:0] {TOT_HOLD, TOT_CLR, TOT_ADD} tot_op_t;
  typedef enum logic [1:0] {CR_NONE, CR_SEED, CR_ADDW, CR_SUBBEST} cr_op_t;
  typedef enum logic [1:0] {IDX_HOLD, IDX_CLR, IDX_INC} idx_op_t;
  typedef enum logic [1:0] {G_HOLD, G_CLR, G_ADD} g_op_t;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_IF_PICK, JMP_IF_MORE, JMP_IF_SLOTS, JMP_END
  } jmp_t;

  typedef struct packed {
    acc_op_t          acc_op;
    mul_op_t          mul_op;
    tot_op_t          tot_op;
    cr_op_t           cr_op;
    idx_op_t          idx_op;
    g_op_t            g_op;
    logic             h_load;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
  } ctrl_word_t;

  localparam ctrl_word_t CTRL_NOP = '{
    acc_op: ACC_HOLD, mul_op: MUL_NONE, tot_op: TOT_HOLD, cr_op: CR_NONE,
    idx_op: IDX_HOLD, g_op: G_HOLD, h_load: 1'b0, jmp: JMP_NEXT, target: '0
  };

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic more_active;
    logic more_slots;
  } dp_status_t;

  typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

  // Clamp the target count into one to MAX_TARGETS
  function automatic logic [CNT_W-1:0] active_count(input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] n;
    n = cnt;
    if (n == '0) n = CNT_W'(1);
    if (n > CNT_W'(MAX_TARGETS)) n = CNT_W'(MAX_TARGETS);
    return n;
  endfunction

  // Pick one importance field and apply the minimum
  function automatic logic [15:0] floored_imp(input logic [63:0] lo, input logic [63:0] hi,
                                              input logic [IDX_W-1:0] idx);
    logic [63:0] reg_sel;
    logic [15:0] v;
    reg_sel = idx[2] ? hi : lo;
    v = reg_sel[idx[1:0]*16 +: 16];
    return (v < IMP_FLOOR) ? IMP_FLOOR : v;
  endfunction

  // Saturate a 49-bit two's complement value to the credit range
  function automatic logic signed [47:0] sat_credit(input logic [48:0] v);
    logic signed [47:0] r;
    if (v[48] != v[47]) begin
      r = v[48] ? CREDIT_MIN : CREDIT_MAX;
    end else begin
      r = $signed(v[47:0]);
    end
    return r;
  endfunction

endpackage

// ===== design/bwrr_ucode_rom.sv =====
// Microcode table: one control word per sequencer step.
module bwrr_ucode_rom (
  input  logic [bwrr_pkg::UPC_W-1:0] upc,
  output bwrr_pkg::ctrl_word_t       word
);

  localparam logic [bwrr_pkg::UPC_W-1:0] STEP_SUM  = 5'd1;
  localparam logic [bwrr_pkg::UPC_W-1:0] STEP_SEED = 5'd8;
  localparam logic [bwrr_pkg::UPC_W-1:0] STEP_PICK = 5'd17;

  // Decode the step into its control word
  always_comb begin
    word = bwrr_pkg::CTRL_NOP;
    case (upc)
      // dispatch on request type
      5'd0: begin
        word.idx_op = bwrr_pkg::IDX_CLR;
        word.tot_op = bwrr_pkg::TOT_CLR;
        word.jmp    = bwrr_pkg::JMP_IF_PICK;
        word.target = STEP_PICK;
      end
      // sum floored importances of active targets
      5'd1: begin
        word.tot_op = bwrr_pkg::TOT_ADD;
        word.idx_op = bwrr_pkg::IDX_INC;
        word.jmp    = bwrr_pkg::JMP_IF_MORE;
        word.target = STEP_SUM;
      end
      // hash the seed
      5'd2: begin
        word.acc_op = bwrr_pkg::ACC_SEED;
        word.idx_op = bwrr_pkg::IDX_CLR;
      end
      5'd3: word.acc_op = bwrr_pkg::ACC_XS16;
      5'd4: word.mul_op = bwrr_pkg::MUL_C1;
      5'd5: word.acc_op = bwrr_pkg::ACC_P_XS15;
      5'd6: word.mul_op = bwrr_pkg::MUL_C2;
      5'd7: begin
        word.acc_op = bwrr_pkg::ACC_P_XS16;
        word.h_load = 1'b1;
        word.g_op   = bwrr_pkg::G_CLR;
      end
      // per slot: hash the offset seed and scale the total
      5'd8:  word.acc_op = bwrr_pkg::ACC_HG;
      5'd9:  word.acc_op = bwrr_pkg::ACC_XS16;
      5'd10: word.mul_op = bwrr_pkg::MUL_C1;
      5'd11: word.acc_op = bwrr_pkg::ACC_P_XS15;
      5'd12: word.mul_op = bwrr_pkg::MUL_C2;
      5'd13: word.acc_op = bwrr_pkg::ACC_P_XS16;
      5'd14: word.mul_op = bwrr_pkg::MUL_TU;
      5'd15: begin
        word.cr_op  = bwrr_pkg::CR_SEED;
        word.idx_op = bwrr_pkg::IDX_INC;
        word.g_op   = bwrr_pkg::G_ADD;
        word.jmp    = bwrr_pkg::JMP_IF_SLOTS;
        word.target = STEP_SEED;
      end
      5'd16: word.jmp = bwrr_pkg::JMP_END;
      // per active target: weight, round, divide by ten, accumulate
      5'd17: word.mul_op = bwrr_pkg::MUL_BN;
      5'd18: word.acc_op = bwrr_pkg::ACC_P_ADD5;
      5'd19: word.mul_op = bwrr_pkg::MUL_DIV;
      5'd20: begin
        word.cr_op  = bwrr_pkg::CR_ADDW;
        word.idx_op = bwrr_pkg::IDX_INC;
        word.jmp    = bwrr_pkg::JMP_IF_MORE;
        word.target = STEP_PICK;
      end
      5'd21: word.cr_op = bwrr_pkg::CR_SUBBEST;
      5'd22: word.jmp   = bwrr_pkg::JMP_END;
      default: word.jmp = bwrr_pkg::JMP_END;
    endcase
  end

endmodule

// ===== design/bwrr_sequencer.sv =====
// Microcode sequencer: step counter, conditional jumps and request latch.
module bwrr_sequencer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 req_type,
  input  bwrr_pkg::dp_status_t status,
  output logic                 busy,
  output logic                 emit,
  output bwrr_pkg::ctrl_word_t ctrl
);

  bwrr_pkg::seq_state_t              state, state_next;
  logic [bwrr_pkg::UPC_W-1:0]        upc, upc_next;
  logic                              pick, pick_next;
  bwrr_pkg::ctrl_word_t              rom_word;
  logic                              take;

  bwrr_ucode_rom u_rom (
    .upc  (upc),
    .word (rom_word)
  );

  assign busy = (state == bwrr_pkg::SEQ_RUN);
  assign take = start && !busy;

  // Hold state, step counter and request type
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwrr_pkg::SEQ_IDLE;
      upc   <= '0;
      pick  <= 1'b0;
    end else begin
      state <= state_next;
      upc   <= upc_next;
      pick  <= pick_next;
    end
  end

  // Advance the step counter and decode jumps
  always_comb begin
    state_next = state;
    upc_next   = upc;
    pick_next  = pick;
    emit       = 1'b0;
    ctrl       = bwrr_pkg::CTRL_NOP;
    case (state)
      bwrr_pkg::SEQ_IDLE: begin
        if (take) begin
          state_next = bwrr_pkg::SEQ_RUN;
          upc_next   = '0;
          pick_next  = (req_type == bwrr_pkg::REQ_PICK);
        end
      end
      bwrr_pkg::SEQ_RUN: begin
        ctrl     = rom_word;
        upc_next = upc + bwrr_pkg::UPC_W'(1);
        case (rom_word.jmp)
          bwrr_pkg::JMP_IF_PICK:  if (pick) upc_next = rom_word.target;
          bwrr_pkg::JMP_IF_MORE:  if (status.more_active) upc_next = rom_word.target;
          bwrr_pkg::JMP_IF_SLOTS: if (status.more_slots) upc_next = rom_word.target;
          bwrr_pkg::JMP_END: begin
            state_next = bwrr_pkg::SEQ_IDLE;
            emit       = pick;
          end
          default: ;
        endcase
      end
      default: state_next = bwrr_pkg::SEQ_IDLE;
    endcase
  end

endmodule

// ===== design/bwrr_datapath.sv =====
// Datapath: shared multiplier, hash and weight registers, credit store and best tracking.
module bwrr_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          load,
  input  logic [10:0]                   hero_emphasis,
  input  logic [31:0]                   seed_value,
  input  logic [bwrr_pkg::CNT_W-1:0]    target_count,
  input  logic [63:0]                   importance_low,
  input  logic [63:0]                   importance_high,
  input  bwrr_pkg::ctrl_word_t          ctrl,
  output bwrr_pkg::dp_status_t          status,
  output logic [bwrr_pkg::IDX_W-1:0]    best
);

  logic [10:0]                   emph;
  logic [31:0]                   acc, acc_next;
  logic [31:0]                   h;
  logic [31:0]                   g;
  logic [63:0]                   prod;
  logic [bwrr_pkg::TOTAL_W-1:0]  total;
  logic [bwrr_pkg::IDX_W-1:0]    idx;
  logic [31:0]                   wsum;
  logic signed [47:0]            best_credit;
  logic signed [47:0]            credit [bwrr_pkg::SLOTS];

  logic [31:0]                   mul_a, mul_b, p;
  logic [63:0]                   mul_res;
  logic [bwrr_pkg::CNT_W-1:0]    n_act;
  logic [15:0]                   b_cur, hero_num, rest_num, num_cur;
  logic                          idx_active;
  logic [bwrr_pkg::W_W-1:0]      w;
  logic [48:0]                   add_sum, sub_sum;
  logic signed [47:0]            add_sat, sub_sat, seed_credit;

  assign p           = prod[31:0];
  assign n_act       = bwrr_pkg::active_count(target_count);
  assign b_cur       = bwrr_pkg::floored_imp(importance_low, importance_high, idx);
  assign hero_num    = 16'd3072 + 16'(emph) * 16'd27;
  assign rest_num    = 16'd17408 - 16'(emph) * 16'd13;
  assign num_cur     = (idx == '0) ? hero_num : rest_num;
  assign idx_active  = {1'b0, idx} < n_act;
  assign w           = prod[62:35];
  assign seed_credit = $signed(prod[61:14]);
  assign add_sum     = {credit[idx][47], credit[idx]} + 49'(w);
  assign add_sat     = bwrr_pkg::sat_credit(add_sum);
  assign sub_sum     = {best_credit[47], best_credit} - 49'(wsum);
  assign sub_sat     = bwrr_pkg::sat_credit(sub_sum);

  assign status.more_active = ({1'b0, idx} + bwrr_pkg::CNT_W'(1)) < n_act;
  assign status.more_slots  = idx != bwrr_pkg::IDX_W'(bwrr_pkg::SLOTS - 1);

  // Select multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctrl.mul_op)
      bwrr_pkg::MUL_C1: begin
        mul_a = acc;
        mul_b = bwrr_pkg::HASH_MUL1;
      end
      bwrr_pkg::MUL_C2: begin
        mul_a = acc;
        mul_b = bwrr_pkg::HASH_MUL2;
      end
      bwrr_pkg::MUL_TU: begin
        mul_a = 32'(total);
        mul_b = {8'd0, acc[23:0]};
      end
      bwrr_pkg::MUL_BN: begin
        mul_a = {16'd0, b_cur};
        mul_b = {16'd0, num_cur};
      end
      bwrr_pkg::MUL_DIV: begin
        mul_a = acc;
        mul_b = bwrr_pkg::DIV10_RECIP;
      end
      default: ;
    endcase
  end

  assign mul_res = mul_a * mul_b;

  // Work out the next accumulator value
  always_comb begin
    acc_next = acc;
    case (ctrl.acc_op)
      bwrr_pkg::ACC_SEED:   acc_next = seed_value;
      bwrr_pkg::ACC_HG:     acc_next = h + g;
      bwrr_pkg::ACC_XS16:   acc_next = acc ^ (acc >> 16);
      bwrr_pkg::ACC_P_XS15: acc_next = p ^ (p >> 15);
      bwrr_pkg::ACC_P_XS16: acc_next = p ^ (p >> 16);
      bwrr_pkg::ACC_P_ADD5: acc_next = p + 32'd5;
      default: ;
    endcase
  end

  // Hold working registers
  always_ff @(posedge clk) begin
    if (load) begin
      emph <= (hero_emphasis > bwrr_pkg::EMPH_ONE) ? bwrr_pkg::EMPH_ONE : hero_emphasis;
    end
    acc <= acc_next;
    if (ctrl.mul_op != bwrr_pkg::MUL_NONE) prod <= mul_res;
    if (ctrl.h_load) h <= acc_next;
    case (ctrl.g_op)
      bwrr_pkg::G_CLR: g <= '0;
      bwrr_pkg::G_ADD: g <= g + bwrr_pkg::GOLDEN;
      default: ;
    endcase
    case (ctrl.tot_op)
      bwrr_pkg::TOT_CLR: total <= '0;
      bwrr_pkg::TOT_ADD: total <= total + bwrr_pkg::TOTAL_W'(b_cur);
      default: ;
    endcase
    case (ctrl.idx_op)
      bwrr_pkg::IDX_CLR: idx <= '0;
      bwrr_pkg::IDX_INC: idx <= idx + bwrr_pkg::IDX_W'(1);
      default: ;
    endcase
  end

  // Track the weight sum and the leading credit during a pick
  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (ctrl.cr_op == bwrr_pkg::CR_ADDW) begin
      if (idx == '0 || add_sat > best_credit) begin
        best <= idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cr_op == bwrr_pkg::CR_ADDW) begin
      wsum <= (idx == '0) ? 32'(w) : wsum + 32'(w);
      if (idx == '0 || add_sat > best_credit) begin
        best_credit <= add_sat;
      end
    end
  end

  // Update the credit store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < bwrr_pkg::SLOTS; k++) credit[k] <= '0;
    end else begin
      case (ctrl.cr_op)
        bwrr_pkg::CR_SEED:    credit[idx]  <= idx_active ? seed_credit : '0;
        bwrr_pkg::CR_ADDW:    credit[idx]  <= add_sat;
        bwrr_pkg::CR_SUBBEST: credit[best] <= sub_sat;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/biased_weighted_round_robin_unit.sv =====
// Pick: walks the n active targets (1..8) and then strobes the result; no new request
// is taken while busy, and the next one can be taken in the strobe cycle.
// Restart: busy while the credits are reseeded, no result; the microcode walks the one
// shared 32x32 multiplier through hashing and weighting.
// The receiver cannot stall: each result stands for exactly one cycle.
// Synchronous reset: configuration registers to defaults, target count one, all credits zero, idle.
module biased_weighted_round_robin_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  bwrr_pkg::req_t req,
  output logic           busy,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [2:0]     cfg_index,
  input  logic [63:0]    cfg_data,
  output logic           result_valid,
  output bwrr_pkg::res_t result
);

  logic [31:0]                  seed_value;
  logic [bwrr_pkg::CNT_W-1:0]   target_count;
  logic [63:0]                  importance_low;
  logic [63:0]                  importance_high;
  bwrr_pkg::ctrl_word_t         ctrl;
  bwrr_pkg::dp_status_t         status;
  logic [bwrr_pkg::IDX_W-1:0]   best;
  logic                         emit;
  logic                         take;

  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_value      <= '0;
      target_count    <= bwrr_pkg::CNT_W'(1);
      importance_low  <= '0;
      importance_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bwrr_pkg::CFG_SEED:     seed_value      <= cfg_data[31:0];
        bwrr_pkg::CFG_COUNT:    target_count    <= cfg_data[bwrr_pkg::CNT_W-1:0];
        bwrr_pkg::CFG_IMP_LOW:  importance_low  <= cfg_data;
        bwrr_pkg::CFG_IMP_HIGH: importance_high <= cfg_data;
        default: ;
      endcase
    end
  end

  bwrr_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .status   (status),
    .busy     (busy),
    .emit     (emit),
    .ctrl     (ctrl)
  );

  bwrr_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .load            (take),
    .hero_emphasis   (req.hero_emphasis),
    .seed_value      (seed_value),
    .target_count    (target_count),
    .importance_low  (importance_low),
    .importance_high (importance_high),
    .ctrl            (ctrl),
    .status          (status),
    .best            (best)
  );

  // Register the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.chosen_target <= best;
      result.is_favored    <= (best == '0);
    end
  end

  assert property (@(posedge clk) disable iff (rst) result_valid |-> !busy)
    else $error("result strobe while sequencer still running");

  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("result strobe held for more than one cycle");

  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.is_favored == (result.chosen_target == '0)))
    else $error("favoured flag disagrees with chosen target");

  assert property (@(posedge clk) disable iff (rst) take |=> busy)
    else $error("request taken but sequencer not running");

endmodule

// ===== dv/biased_weighted_round_robin_unit_tb.sv =====
// Self-checking testbench for the biased weighted round-robin unit: restart and pick requests.
`timescale 1ns / 1ps

module biased_weighted_round_robin_unit_tb;

  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int DRAIN_CYCLES  = 100;
  localparam int RANDOM_PHASES = 24;
  localparam int PHASE_ITEMS   = 65;

  logic           clk;
  logic           rst = 1'b1;
  logic           start = 1'b0;
  bwrr_pkg::req_t req = '0;
  logic           busy;
  logic           cfg_valid = 1'b0;
  logic           cfg_ready;
  logic [2:0]     cfg_index = '0;
  logic [63:0]    cfg_data = '0;
  logic           result_valid;
  bwrr_pkg::res_t result;

  // Mirror of the configuration and the credit state
  logic [31:0]        seed_reg;
  logic [3:0]         count_reg;
  logic [63:0]        imp_lo_reg;
  logic [63:0]        imp_hi_reg;
  logic signed [47:0] credit [8];

  bwrr_pkg::req_t queued_requests [$];
  bwrr_pkg::res_t predicted_choices [$];
  int             sender_idle_pct;
  int             mismatch_count;
  int             cycle_count;

  biased_weighted_round_robin_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .req          (req),
    .busy         (busy),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // 32-bit xorshift-multiply hash
  function automatic logic [31:0] mix32(input logic [31:0] x);
    x = x ^ (x >> 16);
    x = x * bwrr_pkg::HASH_MUL1;
    x = x ^ (x >> 15);
    x = x * bwrr_pkg::HASH_MUL2;
    x = x ^ (x >> 16);
    return x;
  endfunction

  function automatic int targets_in_play();
    int n;
    n = int'(count_reg);
    if (n < 1) n = 1;
    if (n > bwrr_pkg::MAX_TARGETS) n = bwrr_pkg::MAX_TARGETS;
    return n;
  endfunction

  function automatic longint base_weight(input int i);
    logic [63:0] word;
    logic [15:0] v;
    word = (i < 4) ? imp_lo_reg : imp_hi_reg;
    v = word[(i % 4) * 16 +: 16];
    if (v < bwrr_pkg::IMP_FLOOR) v = bwrr_pkg::IMP_FLOOR;
    return longint'(v);
  endfunction

  function automatic logic signed [47:0] clamp_credit(input longint v);
    if (v > longint'(bwrr_pkg::CREDIT_MAX)) return bwrr_pkg::CREDIT_MAX;
    if (v < longint'(bwrr_pkg::CREDIT_MIN)) return bwrr_pkg::CREDIT_MIN;
    return v[47:0];
  endfunction

  // Advance the rotation by one request; a pick leaves its expected choice behind
  task automatic advance_rotation(input bwrr_pkg::req_t r);
    int             n;
    int             best;
    longint         total;
    longint         u;
    longint         e;
    longint         num;
    longint         w;
    longint         wsum;
    logic [31:0]    h;
    logic [31:0]    key;
    bwrr_pkg::res_t choice;
    n = targets_in_play();
    if (r.req_type == bwrr_pkg::REQ_RESTART) begin
      total = 0;
      h = mix32(seed_reg);
      for (int i = 0; i < n; i++) total += base_weight(i);
      for (int i = 0; i < 8; i++) begin
        if (i < n) begin
          key = h + 32'(i) * bwrr_pkg::GOLDEN;
          u = longint'(mix32(key) & 32'h00FF_FFFF);
          credit[i] = clamp_credit((total * u) >>> 14);
        end else begin
          credit[i] = '0;
        end
      end
    end else begin
      e = longint'(r.hero_emphasis);
      if (e > 1024) e = 1024;
      wsum = 0;
      best = 0;
      for (int i = 0; i < n; i++) begin
        num = (i == 0) ? (3072 + 27 * e) : (17408 - 13 * e);
        w = (base_weight(i) * num + 5) / 10;
        wsum += w;
        credit[i] = clamp_credit(longint'(credit[i]) + w);
        if (credit[i] > credit[best]) best = i;
      end
      credit[best] = clamp_credit(longint'(credit[best]) - wsum);
      choice.chosen_target = 3'(best);
      choice.is_favored    = (best == 0);
      predicted_choices.insert(predicted_choices.size(), choice);
    end
  endtask

  // Driver: offer queued requests, hold each until taken
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        advance_rotation(req);
        void'(queued_requests.pop_front());
      end
      if (!(start && busy)) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          start <= 1'b1;
          req   <= queued_requests[0];
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed result with the oldest expected choice
  always @(posedge clk) begin
    if (!rst && result_valid) begin : check_result
      bwrr_pkg::res_t want;
      if (predicted_choices.size() == 0) begin
        $error("unexpected result: chosen_target %0d is_favored %0d",
               result.chosen_target, result.is_favored);
        mismatch_count++;
      end else begin
        want = predicted_choices.pop_front();
        if (result.chosen_target !== want.chosen_target) begin
          $error("chosen_target: expected %0d, got %0d", want.chosen_target,
                 result.chosen_target);
          mismatch_count++;
        end
        if (result.is_favored !== want.is_favored) begin
          $error("is_favored: expected %0d, got %0d", want.is_favored, result.is_favored);
          mismatch_count++;
        end
      end
    end
  end

  // Cycle limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("biased_weighted_round_robin_unit regression: fail");
      $finish;
    end
  end

  task automatic queue_request(input logic kind, input logic [10:0] emphasis);
    bwrr_pkg::req_t r;
    r.req_type      = kind;
    r.hero_emphasis = emphasis;
    queued_requests.insert(queued_requests.size(), r);
  endtask

  // Wait until every request is taken and every result is back, then let the block go quiet
  task automatic settle();
    do @(negedge clk);
    while (queued_requests.size() != 0 || start || predicted_choices.size() != 0 || busy);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [63:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      bwrr_pkg::CFG_SEED:     seed_reg   = value[31:0];
      bwrr_pkg::CFG_COUNT:    count_reg  = value[3:0];
      bwrr_pkg::CFG_IMP_LOW:  imp_lo_reg = value;
      bwrr_pkg::CFG_IMP_HIGH: imp_hi_reg = value;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] seed, input logic [3:0] count,
                           input logic [63:0] lo, input logic [63:0] hi);
    write_register(bwrr_pkg::CFG_SEED, 64'(seed));
    write_register(bwrr_pkg::CFG_COUNT, 64'(count));
    write_register(bwrr_pkg::CFG_IMP_LOW, lo);
    write_register(bwrr_pkg::CFG_IMP_HIGH, hi);
    @(negedge clk);
  endtask

  function automatic logic [10:0] rand_emphasis();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 11'd0;
    if (r < 25) return bwrr_pkg::EMPH_ONE;
    if (r < 40) return 11'($urandom_range(2047, 1025));
    return 11'($urandom_range(1024));
  endfunction

  function automatic logic [3:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 8) return 4'd0;
    if (r < 25) return 4'd8;
    if (r < 35) return 4'($urandom_range(15, 9));
    return 4'($urandom_range(7, 1));
  endfunction

  function automatic logic [63:0] rand_importances();
    logic [63:0] word;
    int          r;
    for (int i = 0; i < 4; i++) begin
      r = $urandom_range(99);
      if (r < 20)      word[i*16 +: 16] = 16'($urandom_range(300));
      else if (r < 30) word[i*16 +: 16] = 16'hFFFF;
      else if (r < 35) word[i*16 +: 16] = bwrr_pkg::IMP_FLOOR;
      else             word[i*16 +: 16] = 16'($urandom);
    end
    return word;
  endfunction

  function automatic logic [31:0] rand_seed();
    int r;
    r = $urandom_range(19);
    if (r == 0) return 32'h0;
    if (r == 1) return 32'hFFFF_FFFF;
    return 32'($urandom);
  endfunction

  initial begin
    seed_reg        = '0;
    count_reg       = 4'd1;
    imp_lo_reg      = '0;
    imp_hi_reg      = '0;
    for (int i = 0; i < 8; i++) credit[i] = '0;
    sender_idle_pct = 0;
    mismatch_count  = 0;
    cycle_count     = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Pick straight out of reset: credits still zero, one target
    queue_request(bwrr_pkg::REQ_PICK, 11'd0);
    settle();

    // Count of zero acts as one; all importances at the floor; emphasis above one
    configure(32'h0, 4'd0, 64'h0, 64'h0);
    queue_request(bwrr_pkg::REQ_RESTART, 11'd0);
    queue_request(bwrr_pkg::REQ_PICK, 11'h7FF);
    queue_request(bwrr_pkg::REQ_PICK, 11'd1025);
    settle();

    // Full rotation, largest importances and values around the floor
    configure(32'hFFFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_00CD_00CC_1000);
    queue_request(bwrr_pkg::REQ_RESTART, 11'h7FF);
    queue_request(bwrr_pkg::REQ_PICK, 11'd0);
    queue_request(bwrr_pkg::REQ_PICK, bwrr_pkg::EMPH_ONE);
    queue_request(bwrr_pkg::REQ_PICK, 11'd512);
    queue_request(bwrr_pkg::REQ_PICK, 11'h7FF);
    queue_request(bwrr_pkg::REQ_PICK, 11'd0);
    settle();

    // Count above the maximum acts as the maximum
    configure(32'h1234_5678, 4'd15, 64'h0001_7FFF_8000_00CE, 64'hFFFF_0000_4000_2000);
    queue_request(bwrr_pkg::REQ_PICK, 11'd700);
    queue_request(bwrr_pkg::REQ_RESTART, 11'd0);
    queue_request(bwrr_pkg::REQ_PICK, bwrr_pkg::EMPH_ONE);
    queue_request(bwrr_pkg::REQ_PICK, 11'd0);
    settle();

    // Shrink the rotation without restart, then grow it back: idle credits rejoin as held
    write_register(bwrr_pkg::CFG_COUNT, 64'd3);
    @(negedge clk);
    queue_request(bwrr_pkg::REQ_PICK, 11'd100);
    queue_request(bwrr_pkg::REQ_PICK, 11'd900);
    settle();
    write_register(bwrr_pkg::CFG_COUNT, 64'd8);
    @(negedge clk);
    queue_request(bwrr_pkg::REQ_PICK, 11'd300);
    queue_request(bwrr_pkg::REQ_PICK, 11'd0);
    settle();

    // Random phases: mostly restart-then-pick runs under changing settings
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      configure(rand_seed(), rand_count(), rand_importances(), rand_importances());
      case (p % 3)
        0:       sender_idle_pct = 0;
        1:       sender_idle_pct = 75;
        default: sender_idle_pct = 38;
      endcase
      if ($urandom_range(9) >= 3) queue_request(bwrr_pkg::REQ_RESTART, rand_emphasis());
      for (int k = 1; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(99) < 10) queue_request(bwrr_pkg::REQ_RESTART, rand_emphasis());
        else                         queue_request(bwrr_pkg::REQ_PICK, rand_emphasis());
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("biased_weighted_round_robin_unit regression: pass");
    end else begin
      $display("biased_weighted_round_robin_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/bwrr_pkg.sv
design/bwrr_ucode_rom.sv
design/bwrr_sequencer.sv
design/bwrr_datapath.sv
design/biased_weighted_round_robin_unit.sv
dv/biased_weighted_round_robin_unit_tb.sv
